[rtl/euler_step_speed_clamp_assert.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the Euler step block
// Shared property forms used by the port checker.
// ---------------------------------------------------------------------------
`ifndef EULER_STEP_SPEED_CLAMP_ASSERT_SVH
`define EULER_STEP_SPEED_CLAMP_ASSERT_SVH

// Same-cycle implication, disabled while reset is high
`define ESC_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high
`define ESC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/esc_pkg.sv]
// ---------------------------------------------------------------------------
// esc_pkg
// Types, widths, stage counts and helpers of the Euler step block.
// ---------------------------------------------------------------------------
package esc_pkg;

   localparam int FRACTION_BITS_DEF = 16;
   localparam int DATA_W       = 32;
   localparam int MAG_W        = 31;
   localparam int DT_W         = 21;
   localparam int PROD_W       = DATA_W + DT_W + 1;
   localparam int NUM_LANES    = 3;
   localparam int FRONT_STAGES = 3;
   localparam int ROOT_BITS    = 32;
   localparam int SQ_W         = 2 * DATA_W;
   localparam int SQRT_STAGES  = ROOT_BITS + 1;
   localparam int QUO_BITS     = 31;
   localparam int NUM_W        = DATA_W + MAG_W;
   localparam int LANE_LAT     = FRONT_STAGES + SQRT_STAGES + 1 + QUO_BITS + 2;
   localparam int RSP_LAT      = LANE_LAT + 1;
   localparam int CSR_IDX_W    = 3;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_ENABLE    = 3'd0,
      REG_GRAV_X    = 3'd1,
      REG_GRAV_Y    = 3'd2,
      REG_GRAV_Z    = 3'd3,
      REG_TIME_STEP = 3'd4
   } csr_reg_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] vel_x;
      logic signed [DATA_W-1:0] vel_y;
      logic signed [DATA_W-1:0] vel_z;
      logic signed [DATA_W-1:0] pos_x;
      logic signed [DATA_W-1:0] pos_y;
      logic signed [DATA_W-1:0] pos_z;
      logic [MAG_W-1:0]         body_mass;
      logic                     use_gravity;
      logic                     is_kinematic;
      logic [MAG_W-1:0]         max_speed;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] new_vel_x;
      logic signed [DATA_W-1:0] new_vel_y;
      logic signed [DATA_W-1:0] new_vel_z;
      logic signed [DATA_W-1:0] new_pos_x;
      logic signed [DATA_W-1:0] new_pos_y;
      logic signed [DATA_W-1:0] new_pos_z;
      logic                     mass_error;
   } rsp_type;

   // root unit to lanes: magnitude root, clamp decision and the limit
   typedef struct packed {
      logic [ROOT_BITS-1:0] root;
      logic                 clamp;
      logic [MAG_W-1:0]     lim;
   } root_type;

   // base + floor(prod / 2^fbits), saturated to 32 bit signed
   function automatic logic signed [DATA_W-1:0] sat_add_shift(
      input logic signed [DATA_W-1:0] base,
      input logic signed [PROD_W-1:0] prod,
      input int unsigned              fbits);
      logic signed [PROD_W-1:0] sh;
      logic signed [PROD_W:0]   sum;
      logic signed [PROD_W:0]   hi;
      logic signed [PROD_W:0]   lo;
      sh  = prod >>> fbits;
      sum = {{(PROD_W+1-DATA_W){base[DATA_W-1]}}, base} + {sh[PROD_W-1], sh};
      hi  = {{(PROD_W+1-DATA_W){1'b0}}, 1'b0, {(DATA_W-1){1'b1}}};
      lo  = {{(PROD_W+1-DATA_W){1'b1}}, 1'b1, {(DATA_W-1){1'b0}}};
      if (sum > hi) begin
         return {1'b0, {(DATA_W-1){1'b1}}};
      end else if (sum < lo) begin
         return {1'b1, {(DATA_W-1){1'b0}}};
      end
      return sum[DATA_W-1:0];
   endfunction

   // absolute value as unsigned, exact for the most negative value
   function automatic logic [DATA_W-1:0] mag(input logic signed [DATA_W-1:0] v);
      logic [DATA_W-1:0] neg;
      neg = DATA_W'(-v);
      return v[DATA_W-1] ? neg : v;
   endfunction

endpackage

[rtl/esc_lane.sv]
// ---------------------------------------------------------------------------
// esc_lane
// One vector component: gravity update, square, clamp division by the
// shared root and position update, fully pipelined.
// ---------------------------------------------------------------------------
module esc_lane import esc_pkg::*; #(
   parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
   input  logic                     clock,
   input  logic signed [DATA_W-1:0] vel,
   input  logic signed [DATA_W-1:0] pos,
   input  logic signed [DATA_W-1:0] grav,
   input  logic [DT_W-1:0]          dt,
   input  logic                     apply_grav,
   input  logic                     active,
   output logic [SQ_W-1:0]          sq,
   input  root_type                 root_in,
   output logic signed [DATA_W-1:0] new_vel,
   output logic signed [DATA_W-1:0] new_pos
);

   logic signed [PROD_W-1:0] a_prod_ff;
   logic signed [DATA_W-1:0] a_v_ff, a_p_ff;
   logic                     a_g_ff, a_act_ff;
   logic signed [DATA_W-1:0] b_v_ff, b_p_ff;
   logic                     b_act_ff;
   logic [SQ_W-1:0]          c_sq_ff;
   logic signed [DATA_W-1:0] c_v_ff, c_p_ff;
   logic                     c_act_ff;
   logic signed [DATA_W-1:0] d_v_ff [SQRT_STAGES];
   logic signed [DATA_W-1:0] d_p_ff [SQRT_STAGES];
   logic                     d_act_ff [SQRT_STAGES];
   logic [NUM_W-1:0]         q_rem_ff   [QUO_BITS+1];
   logic [QUO_BITS-1:0]      q_quo_ff   [QUO_BITS+1];
   logic [ROOT_BITS-1:0]     q_root_ff  [QUO_BITS+1];
   logic                     q_neg_ff   [QUO_BITS+1];
   logic                     q_clamp_ff [QUO_BITS+1];
   logic signed [DATA_W-1:0] q_v_ff     [QUO_BITS+1];
   logic signed [DATA_W-1:0] q_p_ff     [QUO_BITS+1];
   logic                     q_act_ff   [QUO_BITS+1];
   logic signed [DATA_W-1:0] v2;
   logic [DATA_W-1:0]        qs;
   logic signed [DATA_W-1:0] f_v_ff, f_p_ff;
   logic signed [PROD_W-1:0] f_prod_ff;
   logic                     f_act_ff;
   logic signed [DATA_W-1:0] g_v_ff, g_p_ff;

   // gravity times time step
   always_ff @(posedge clock) begin
      a_prod_ff <= $signed(grav) * $signed({1'b0, dt});
      a_v_ff    <= vel;
      a_p_ff    <= pos;
      a_g_ff    <= apply_grav;
      a_act_ff  <= active;
   end

   // add velocity change with saturation
   always_ff @(posedge clock) begin
      b_v_ff   <= a_g_ff ? sat_add_shift(a_v_ff, a_prod_ff, FRACTION_BITS) : a_v_ff;
      b_p_ff   <= a_p_ff;
      b_act_ff <= a_act_ff;
   end

   // square of the component
   always_ff @(posedge clock) begin
      c_sq_ff  <= mag(b_v_ff) * mag(b_v_ff);
      c_v_ff   <= b_v_ff;
      c_p_ff   <= b_p_ff;
      c_act_ff <= b_act_ff;
   end

   assign sq = c_sq_ff;

   // hold the component while the root unit works
   always_ff @(posedge clock) begin
      d_v_ff[0]   <= c_v_ff;
      d_p_ff[0]   <= c_p_ff;
      d_act_ff[0] <= c_act_ff;
      for (int k = 1; k < SQRT_STAGES; k++) begin
         d_v_ff[k]   <= d_v_ff[k-1];
         d_p_ff[k]   <= d_p_ff[k-1];
         d_act_ff[k] <= d_act_ff[k-1];
      end
   end

   // scaled numerator |v| * limit
   always_ff @(posedge clock) begin
      q_rem_ff[0]   <= mag(d_v_ff[SQRT_STAGES-1]) * root_in.lim;
      q_quo_ff[0]   <= '0;
      q_root_ff[0]  <= root_in.root;
      q_neg_ff[0]   <= d_v_ff[SQRT_STAGES-1][DATA_W-1];
      q_clamp_ff[0] <= root_in.clamp;
      q_v_ff[0]     <= d_v_ff[SQRT_STAGES-1];
      q_p_ff[0]     <= d_p_ff[SQRT_STAGES-1];
      q_act_ff[0]   <= d_act_ff[SQRT_STAGES-1];
   end

   // restoring division, one quotient bit per stage
   for (genvar j = 0; j < QUO_BITS; j++) begin : g_div
      localparam int B = QUO_BITS - 1 - j;
      logic [NUM_W-1:0] trial;
      assign trial = NUM_W'(q_root_ff[j]) << B;
      always_ff @(posedge clock) begin
         if (q_rem_ff[j] >= trial) begin
            q_rem_ff[j+1] <= q_rem_ff[j] - trial;
            q_quo_ff[j+1] <= q_quo_ff[j] | (QUO_BITS'(1) << B);
         end else begin
            q_rem_ff[j+1] <= q_rem_ff[j];
            q_quo_ff[j+1] <= q_quo_ff[j];
         end
         q_root_ff[j+1]  <= q_root_ff[j];
         q_neg_ff[j+1]   <= q_neg_ff[j];
         q_clamp_ff[j+1] <= q_clamp_ff[j];
         q_v_ff[j+1]     <= q_v_ff[j];
         q_p_ff[j+1]     <= q_p_ff[j];
         q_act_ff[j+1]   <= q_act_ff[j];
      end
   end

   // pick clamped or kept velocity, start the position step
   always_comb begin
      qs = {1'b0, q_quo_ff[QUO_BITS]};
      if (q_act_ff[QUO_BITS] && q_clamp_ff[QUO_BITS]) begin
         v2 = q_neg_ff[QUO_BITS] ? DATA_W'(-qs) : qs;
      end else begin
         v2 = q_v_ff[QUO_BITS];
      end
   end

   always_ff @(posedge clock) begin
      f_v_ff    <= v2;
      f_prod_ff <= $signed(v2) * $signed({1'b0, dt});
      f_p_ff    <= q_p_ff[QUO_BITS];
      f_act_ff  <= q_act_ff[QUO_BITS];
   end

   // add position change with saturation
   always_ff @(posedge clock) begin
      g_v_ff <= f_v_ff;
      g_p_ff <= f_act_ff ? sat_add_shift(f_p_ff, f_prod_ff, FRACTION_BITS) : f_p_ff;
   end

   assign new_vel = g_v_ff;
   assign new_pos = g_p_ff;

endmodule

[rtl/esc_root.sv]
// ---------------------------------------------------------------------------
// esc_root
// Merge stage: sums the lane squares, compares with the squared limit and
// takes the integer square root, one result bit per stage.
// ---------------------------------------------------------------------------
module esc_root import esc_pkg::*; (
   input  logic             clock,
   input  logic [SQ_W-1:0]  sq [NUM_LANES],
   input  logic [MAG_W-1:0] lim,
   output root_type         root_out
);

   logic [SQ_W-1:0]    n_ff     [ROOT_BITS+1];
   logic [SQ_W-1:0]    res_ff   [ROOT_BITS+1];
   logic [MAG_W-1:0]   lim_ff   [ROOT_BITS+1];
   logic               clamp_ff [1:ROOT_BITS];
   logic [2*MAG_W-1:0] lim2_ff;
   logic [SQ_W-1:0]    sum;

   // total of the squares
   always_comb begin
      sum = '0;
      for (int i = 0; i < NUM_LANES; i++) begin
         sum = sum + sq[i];
      end
   end

   always_ff @(posedge clock) begin
      n_ff[0]   <= sum;
      res_ff[0] <= '0;
      lim_ff[0] <= lim;
      lim2_ff   <= lim * lim;
   end

   // digit-by-digit root, two radicand bits per stage
   for (genvar k = 0; k < ROOT_BITS; k++) begin : g_sqrt
      localparam int SH = SQ_W - 2 - 2 * k;
      logic [SQ_W-1:0] bitv;
      logic [SQ_W-1:0] trial;
      assign bitv  = SQ_W'(1) << SH;
      assign trial = res_ff[k] + bitv;
      always_ff @(posedge clock) begin
         if (n_ff[k] >= trial) begin
            n_ff[k+1]   <= n_ff[k] - trial;
            res_ff[k+1] <= (res_ff[k] >> 1) + bitv;
         end else begin
            n_ff[k+1]   <= n_ff[k];
            res_ff[k+1] <= res_ff[k] >> 1;
         end
         lim_ff[k+1] <= lim_ff[k];
      end
      if (k == 0) begin : g_cmp
         always_ff @(posedge clock) begin
            clamp_ff[1] <= n_ff[0] > SQ_W'(lim2_ff);
         end
      end else begin : g_hold
         always_ff @(posedge clock) begin
            clamp_ff[k+1] <= clamp_ff[k];
         end
      end
   end

   assign root_out.root  = res_ff[ROOT_BITS][ROOT_BITS-1:0];
   assign root_out.clamp = clamp_ff[ROOT_BITS];
   assign root_out.lim   = lim_ff[ROOT_BITS];

endmodule

[rtl/euler_step_speed_clamp.sv]
// ---------------------------------------------------------------------------
// euler_step_speed_clamp
// One explicit Euler step per body with gravity and a speed limit, on three
// component lanes joined by a shared square-root stage.
//
//   channel   ports                       direction  handshake
//   request   start, busy, req_data       in         start && !busy
//   result    rsp_valid, rsp_data         out        one-cycle strobe
//   config    csr_we, csr_index, csr_wdata in        write when csr_we
//
// One request per cycle; busy stays low. Results come out in the order of
// their requests; the depth is set by the 32-stage root unit and the
// 31-stage divider in each lane.
// Reset is synchronous, clears the valid bits, gravity, time step; sets enable.
// The receiver takes every result when shown.
// ---------------------------------------------------------------------------
module euler_step_speed_clamp import esc_pkg::*; #(
   parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  req_type              req_data,
   output logic                 rsp_valid,
   output rsp_type              rsp_data,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DATA_W-1:0]    csr_wdata
);

   logic                     enable_ff;
   logic signed [DATA_W-1:0] grav_ff [NUM_LANES];
   logic [DT_W-1:0]          dt_ff;
   req_type                  req_ff;
   logic                     act_ff, agrav_ff;
   logic                     act_in, err_in;
   logic                     vld_ff [LANE_LAT+1];
   logic                     err_ff [LANE_LAT+1];
   logic [MAG_W-1:0]         lim_ff [FRONT_STAGES];
   logic signed [DATA_W-1:0] lane_v [NUM_LANES];
   logic signed [DATA_W-1:0] lane_p [NUM_LANES];
   logic [SQ_W-1:0]          lane_sq [NUM_LANES];
   logic signed [DATA_W-1:0] lane_nv [NUM_LANES];
   logic signed [DATA_W-1:0] lane_np [NUM_LANES];
   root_type                 root_w;

   assign busy = 1'b0;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b1;
         dt_ff     <= '0;
         for (int i = 0; i < NUM_LANES; i++) begin
            grav_ff[i] <= '0;
         end
      end else if (csr_we) begin
         case (csr_reg_type'(csr_index))
            REG_ENABLE:    enable_ff  <= csr_wdata[0];
            REG_GRAV_X:    grav_ff[0] <= csr_wdata;
            REG_GRAV_Y:    grav_ff[1] <= csr_wdata;
            REG_GRAV_Z:    grav_ff[2] <= csr_wdata;
            REG_TIME_STEP: dt_ff      <= csr_wdata[DT_W-1:0];
            default: ;
         endcase
      end
   end

   // decide per request: integrate, flag or pass through
   always_comb begin
      err_in = enable_ff && req_data.is_kinematic && req_data.use_gravity
               && (req_data.body_mass == '0);
      act_in = enable_ff && req_data.is_kinematic && !err_in;
   end

   always_ff @(posedge clock) begin
      req_ff   <= req_data;
      act_ff   <= act_in;
      agrav_ff <= act_in && req_data.use_gravity;
      err_ff[0] <= err_in;
      for (int k = 1; k <= LANE_LAT; k++) begin
         err_ff[k] <= err_ff[k-1];
      end
   end

   // valid bits track each request to the output
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= LANE_LAT; k++) begin
            vld_ff[k] <= 1'b0;
         end
      end else begin
         vld_ff[0] <= start && !busy;
         for (int k = 1; k <= LANE_LAT; k++) begin
            vld_ff[k] <= vld_ff[k-1];
         end
      end
   end

   // align the speed limit with the lane squares
   always_ff @(posedge clock) begin
      lim_ff[0] <= req_ff.max_speed;
      for (int k = 1; k < FRONT_STAGES; k++) begin
         lim_ff[k] <= lim_ff[k-1];
      end
   end

   assign lane_v[0] = req_ff.vel_x;
   assign lane_v[1] = req_ff.vel_y;
   assign lane_v[2] = req_ff.vel_z;
   assign lane_p[0] = req_ff.pos_x;
   assign lane_p[1] = req_ff.pos_y;
   assign lane_p[2] = req_ff.pos_z;

   for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
      esc_lane #(.FRACTION_BITS(FRACTION_BITS)) u_lane (
         .clock      (clock),
         .vel        (lane_v[i]),
         .pos        (lane_p[i]),
         .grav       (grav_ff[i]),
         .dt         (dt_ff),
         .apply_grav (agrav_ff),
         .active     (act_ff),
         .sq         (lane_sq[i]),
         .root_in    (root_w),
         .new_vel    (lane_nv[i]),
         .new_pos    (lane_np[i])
      );
   end

   esc_root u_root (
      .clock    (clock),
      .sq       (lane_sq),
      .lim      (lim_ff[FRONT_STAGES-1]),
      .root_out (root_w)
   );

   // drive the result
   assign rsp_valid           = vld_ff[LANE_LAT];
   assign rsp_data.new_vel_x  = lane_nv[0];
   assign rsp_data.new_vel_y  = lane_nv[1];
   assign rsp_data.new_vel_z  = lane_nv[2];
   assign rsp_data.new_pos_x  = lane_np[0];
   assign rsp_data.new_pos_y  = lane_np[1];
   assign rsp_data.new_pos_z  = lane_np[2];
   assign rsp_data.mass_error = err_ff[LANE_LAT];

endmodule

[rtl/esc_checker.sv]
// ---------------------------------------------------------------------------
// esc_checker
// Port-level checks of the Euler step block, bound to the top level.
// ---------------------------------------------------------------------------
`include "euler_step_speed_clamp_assert.svh"

module esc_checker import esc_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input req_type req_data,
   input logic    rsp_valid,
   input rsp_type rsp_data
);

   // every result traces back to a request a fixed latency earlier
   `ESC_ASSERT_NOW(a_rsp_has_req, clock, reset, rsp_valid, $past(start && !busy, RSP_LAT), "result without a matching request")

   // a flagged body had zero mass, gravity and the kinematic flag
   `ESC_ASSERT_NOW(a_err_cause, clock, reset, rsp_valid && rsp_data.mass_error, $past(req_data.use_gravity && req_data.is_kinematic && (req_data.body_mass == '0), RSP_LAT), "mass error without its cause")

   // a flagged body passes through unchanged (checked on x velocity and z position)
   `ESC_ASSERT_NOW(a_err_pass, clock, reset, rsp_valid && rsp_data.mass_error, (rsp_data.new_vel_x == $past(req_data.vel_x, RSP_LAT)) && (rsp_data.new_pos_z == $past(req_data.pos_z, RSP_LAT)), "flagged body was modified")

   // the pipeline never stalls the requester
   `ESC_ASSERT_NEXT(a_never_busy, clock, reset, 1'b1, !busy, "busy raised")

endmodule

bind euler_step_speed_clamp esc_checker u_esc_checker (.*);

[tb/tb.sv]
// ---------------------------------------------------------------------------
// Euler step block testbench
// Streams rigid-body requests through the block under several register
// settings and checks each whole result against a predictor
// of the integration step, speed clamp and zero-mass check.
// ---------------------------------------------------------------------------
module tb;
   import esc_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DRAIN_CYCLES = RSP_LAT + 20;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   logic                 busy;
   req_type              req_data = '0;
   logic                 rsp_valid;
   rsp_type              rsp_data;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = REG_ENABLE;
   logic [DATA_W-1:0]    csr_wdata = '0;

   // predictor copy of the registers
   logic                    cfg_enable;
   logic signed [31:0]      cfg_grav [3];
   logic [DT_W-1:0]         cfg_dt;

   rsp_type     body_queue [$];
   int          mismatch_count = 0;
   int          result_count = 0;
   int          request_count = 0;
   int          error_count = 0;
   int          clamp_count = 0;
   int unsigned idle_pct = 0;

   euler_step_speed_clamp dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #10 clock = ~clock;

   // base + floor(prod / 2^16), saturated to 32 bit signed
   function automatic logic signed [31:0] step_add(input logic signed [31:0] base,
                                                  input logic signed [63:0] prod);
      logic signed [63:0] sum;
      sum = 64'(base) + (prod >>> FRACTION_BITS_DEF);
      if (sum > 64'sd2147483647) return 32'sh7fffffff;
      if (sum < -64'sd2147483648) return 32'sh80000000;
      return sum[31:0];
   endfunction

   function automatic logic [63:0] root_floor(input logic [63:0] n);
      logic [63:0] res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv >>= 2;
      while (bitv != 0) begin
         if (n >= res + bitv) begin
            n -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   function automatic rsp_type euler_step(input req_type b);
      rsp_type            r;
      logic signed [63:0] v [3];
      logic signed [63:0] p [3];
      logic signed [63:0] dt, lim, rt;
      logic [63:0]        s, a;
      logic signed [127:0] q;
      v[0] = b.vel_x; v[1] = b.vel_y; v[2] = b.vel_z;
      p[0] = b.pos_x; p[1] = b.pos_y; p[2] = b.pos_z;
      dt = {43'd0, cfg_dt};
      lim = {33'd0, b.max_speed};
      r.mass_error = 1'b0;
      if (cfg_enable && b.is_kinematic) begin
         if (b.use_gravity && b.body_mass == 0) begin
            r.mass_error = 1'b1;
         end else begin
            if (b.use_gravity)
               for (int i = 0; i < 3; i++)
                  v[i] = step_add(v[i][31:0], 64'(cfg_grav[i]) * dt);
            s = 0;
            for (int i = 0; i < 3; i++) begin
               a = v[i] < 0 ? -v[i] : v[i];
               s += a * a;
            end
            if (s > 64'(lim) * 64'(lim)) begin
               rt = root_floor(s);
               clamp_count++;
               for (int i = 0; i < 3; i++) begin
                  q = (128'(v[i]) * 128'(lim)) / 128'(rt);
                  v[i] = q[63:0];
               end
            end
            for (int i = 0; i < 3; i++)
               p[i] = step_add(p[i][31:0], v[i] * dt);
         end
      end
      r.new_vel_x = v[0][31:0]; r.new_vel_y = v[1][31:0]; r.new_vel_z = v[2][31:0];
      r.new_pos_x = p[0][31:0]; r.new_pos_y = p[1][31:0]; r.new_pos_z = p[2][31:0];
      return r;
   endfunction

   // compare every strobed result with the oldest expected body
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid) begin
         result_count++;
         if (body_queue.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("unexpected result %h", rsp_data);
         end else begin
            want = body_queue.pop_front();
            if (want.mass_error) error_count++;
            if (rsp_data !== want) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: vel %h %h %h/%h %h %h pos %h %h %h/%h %h %h err %b/%b",
                     want.new_vel_x, want.new_vel_y, want.new_vel_z,
                     rsp_data.new_vel_x, rsp_data.new_vel_y, rsp_data.new_vel_z,
                     want.new_pos_x, want.new_pos_y, want.new_pos_z,
                     rsp_data.new_pos_x, rsp_data.new_pos_y, rsp_data.new_pos_z,
                     want.mass_error, rsp_data.mass_error);
            end
         end
      end
   end

   // send one request, idling first at the current rate
   task automatic send_body(input req_type b);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      req_data <= b;
      start <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      body_queue.push_back(euler_step(b));
      request_count++;
      @(negedge clock);
   endtask

   // write a register; block must be drained
   task automatic write_reg(input csr_reg_type idx, input logic [31:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      case (idx)
         REG_ENABLE:    cfg_enable = val[0];
         REG_GRAV_X:    cfg_grav[0] = val;
         REG_GRAV_Y:    cfg_grav[1] = val;
         REG_GRAV_Z:    cfg_grav[2] = val;
         REG_TIME_STEP: cfg_dt = val[DT_W-1:0];
         default: ;
      endcase
   endtask

   task automatic drain;
      start <= 1'b0;
      while (body_queue.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic set_config(input logic en, input logic [31:0] gx, input logic [31:0] gy,
                             input logic [31:0] gz, input logic [31:0] dt);
      drain();
      write_reg(REG_ENABLE, {31'd0, en});
      write_reg(REG_GRAV_X, gx);
      write_reg(REG_GRAV_Y, gy);
      write_reg(REG_GRAV_Z, gz);
      write_reg(REG_TIME_STEP, dt);
      csr_we <= 1'b0;
   endtask

   function automatic logic [31:0] rand_word(input int span);
      logic [31:0] w;
      w = $urandom();
      case ($urandom_range(3))
         0: return w;
         1: return $signed(w) >>> (32 - span);
         2: return w[0] ? 32'h80000000 : 32'h7fffffff;
         default: return $signed(w) >>> 12;
      endcase
   endfunction

   function automatic req_type rand_body();
      req_type b;
      b.vel_x = rand_word(24); b.vel_y = rand_word(24); b.vel_z = rand_word(24);
      b.pos_x = rand_word(28); b.pos_y = rand_word(28); b.pos_z = rand_word(28);
      b.body_mass = ($urandom_range(7) == 0) ? '0 : MAG_W'($urandom());
      b.use_gravity = 1'($urandom_range(1));
      b.is_kinematic = ($urandom_range(9) != 0);
      case ($urandom_range(4))
         0: b.max_speed = '0;
         1: b.max_speed = '1;
         2: b.max_speed = MAG_W'($urandom());
         default: b.max_speed = MAG_W'($urandom_range(1 << 22));
      endcase
      return b;
   endfunction

   function automatic req_type make_body(input logic [31:0] v, input logic [31:0] p,
                                         input logic [30:0] m, input logic g,
                                         input logic k, input logic [30:0] lim);
      req_type b;
      b.vel_x = v; b.vel_y = -v; b.vel_z = v >>> 1;
      b.pos_x = p; b.pos_y = ~p; b.pos_z = p >>> 3;
      b.body_mass = m; b.use_gravity = g; b.is_kinematic = k; b.max_speed = lim;
      return b;
   endfunction

   // extremes, zero velocity, zero limit, zero mass, pass-through
   task automatic test_directed;
      req_type b;
      set_config(1'b1, 32'hfff63333, 32'h00010000, 32'h7fffffff, 32'h00000ccd);
      send_body(make_body(32'h0, 32'h0, 31'h10000, 1'b0, 1'b1, 31'h10000));
      send_body(make_body(32'h00050000, 32'h00020000, 31'h10000, 1'b1, 1'b1, 31'h0));
      send_body(make_body(32'h00050000, 32'h7fffffff, 31'h0, 1'b1, 1'b1, '1));
      send_body(make_body(32'h00050000, 32'h80000000, 31'h0, 1'b0, 1'b1, 31'h20000));
      send_body(make_body(32'h80000000, 32'h7fffffff, '1, 1'b1, 1'b1, '1));
      send_body(make_body(32'h7fffffff, 32'h80000000, 31'h1, 1'b1, 1'b0, 31'h1));
      send_body(make_body(32'h7fffffff, 32'h80000000, 31'h1, 1'b0, 1'b1, '1));
      b = make_body(32'h80000000, 32'h80000000, 31'h5, 1'b0, 1'b1, 31'h1);
      b.vel_y = 32'h80000000;
      send_body(b);
      set_config(1'b1, 32'h80000000, 32'h7fffffff, 32'h80000000, 32'h00100000);
      send_body(make_body(32'h7fff0000, 32'h7fff0000, 31'h1, 1'b1, 1'b1, '1));
      send_body(make_body(32'h80000000, 32'h80000000, 31'h1, 1'b1, 1'b1, '1));
      send_body(make_body(32'h00001234, 32'h00000001, '1, 1'b1, 1'b1, 31'h100));
      set_config(1'b0, 32'h00010000, 32'h00010000, 32'h00010000, 32'h001fffff);
      send_body(make_body(32'h00050000, 32'h00020000, 31'h0, 1'b1, 1'b1, 31'h0));
      send_body(make_body(32'h7fffffff, 32'h00020000, 31'h1, 1'b0, 1'b1, 31'h0));
   endtask

   task automatic random_phase(input int n);
      repeat (n) send_body(rand_body());
   endtask

   // random bodies under several register settings and idle rates
   task automatic test_random;
      set_config(1'b1, 32'hfff63333, 32'h0, 32'h0, 32'h00000444);
      idle_pct = 7;
      random_phase(350);
      set_config(1'b1, $urandom(), $urandom(), $urandom(), $urandom_range(1 << 20));
      random_phase(250);
      set_config(1'b0, $urandom(), $urandom(), $urandom(), $urandom_range(1 << 20));
      idle_pct = 68;
      random_phase(150);
      set_config(1'b1, 32'h7fffffff, 32'h80000000, 32'h0, 32'h00100000);
      random_phase(250);
      set_config(1'b1, rand_word(20), rand_word(20), rand_word(20), 32'h0);
      idle_pct = 0;
      random_phase(250);
      set_config(1'b1, rand_word(24), rand_word(24), rand_word(24), $urandom_range(1 << 17));
      random_phase(500);
   endtask

   initial begin
      cfg_enable = 1'b1;
      cfg_grav[0] = 0; cfg_grav[1] = 0; cfg_grav[2] = 0;
      cfg_dt = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_random();
      start <= 1'b0;
      while (body_queue.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      $display("%0d bodies sent, %0d results checked, %0d clamped, %0d zero-mass flags",
               request_count, result_count, clamp_count, error_count);
      if (mismatch_count == 0 && body_queue.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("%0d mismatches", mismatch_count);
         $display("simulation failed");
      end
      $finish;
   end

   // hold a hard stop well past the slowest correct run
   initial begin
      #5ms;
      $display("simulation failed");
      $finish;
   end
endmodule

[sim.f]
+incdir+rtl
rtl/esc_pkg.sv
rtl/esc_lane.sv
rtl/esc_root.sv
rtl/euler_step_speed_clamp.sv
rtl/esc_checker.sv
tb/tb.sv
